// ===== rtl/csu_pkg.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity unit package
// Shared widths, constants and structures of the cosine similarity unit.
// ----------------------------------------------------------------------------
package csu_pkg;

    localparam int ACC_W  = 48;
    localparam int WIDE_W = 2 * ACC_W;
    localparam int MUL_W  = ACC_W / 2;
    localparam int THR_W  = 24;
    localparam int RES_W  = 16;
    localparam int QUO_W  = 2 * RES_W;
    localparam int ROOT_W = RES_W;
    localparam int CNT_W  = 5;

    localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
    localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};

    localparam logic [RES_W-1:0] Q_ONE = {1'b1, {(RES_W-1){1'b0}}};
    localparam logic [RES_W-1:0] Q_MAX = {1'b0, {(RES_W-1){1'b1}}};

    localparam logic [CNT_W-1:0] MUL_LAST  = CNT_W'(8);
    localparam logic [CNT_W-1:0] DIV_LAST  = CNT_W'(QUO_W - 1);
    localparam logic [CNT_W-1:0] SQRT_LAST = CNT_W'(ROOT_W - 1);

    typedef struct packed {
        logic [ACC_W-1:0] dot;
        logic [ACC_W-1:0] norm_a;
        logic [ACC_W-1:0] norm_b;
    } t_sums;

    typedef struct packed {
        logic [RES_W-1:0] similarity;
        logic             degenerate;
    } t_result;

endpackage

// ===== rtl/csu_mul.sv =====
// ----------------------------------------------------------------------------
// Registered multiplier
// Unsigned multiplier with a registered product, shared by the sequencer.
// ----------------------------------------------------------------------------
module csu_mul #(
    parameter int W = 24
) (
    input  logic           i_clk,
    input  logic [W-1:0]   i_a,
    input  logic [W-1:0]   i_b,
    output logic [2*W-1:0] o_p
);

    logic [2*W-1:0] r_p;

    always_ff @(posedge i_clk) begin
        r_p <= i_a * i_b;
    end

    assign o_p = r_p;

endmodule

// ===== rtl/csu_accum.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity accumulator
// Two-stage multiply and saturating accumulate of the dot product and the
// two sums of squares, one element pair per cycle.
// ----------------------------------------------------------------------------
module csu_accum #(
    parameter int ELEM_WIDTH = 16
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic signed [ELEM_WIDTH-1:0] i_elem_a,
    input  logic signed [ELEM_WIDTH-1:0] i_elem_b,
    input  logic                         i_last,
    output logic                         o_done,
    output csu_pkg::t_sums               o_sums
);

    localparam int PROD_W = 2 * ELEM_WIDTH;
    localparam int SUM_W  = ((PROD_W > csu_pkg::ACC_W) ? PROD_W : csu_pkg::ACC_W) + 1;

    logic                             r_p_valid;
    logic                             r_p_last;
    logic signed [PROD_W-1:0]         r_p_ab;
    logic signed [PROD_W-1:0]         r_p_aa;
    logic signed [PROD_W-1:0]         r_p_bb;
    logic signed [csu_pkg::ACC_W-1:0] r_dot;
    logic signed [csu_pkg::ACC_W-1:0] r_na;
    logic signed [csu_pkg::ACC_W-1:0] r_nb;
    logic signed [csu_pkg::ACC_W-1:0] n_dot;
    logic signed [csu_pkg::ACC_W-1:0] n_na;
    logic signed [csu_pkg::ACC_W-1:0] n_nb;

    function automatic logic signed [csu_pkg::ACC_W-1:0] sat_add(
        input logic signed [csu_pkg::ACC_W-1:0] acc,
        input logic signed [PROD_W-1:0]         prod
    );
        logic signed [SUM_W-1:0] s;
        s = SUM_W'(acc) + SUM_W'(prod);
        if (s > SUM_W'(csu_pkg::ACC_MAX)) begin
            return csu_pkg::ACC_MAX;
        end else if (s < SUM_W'(csu_pkg::ACC_MIN)) begin
            return csu_pkg::ACC_MIN;
        end
        return s[csu_pkg::ACC_W-1:0];
    endfunction

    always_ff @(posedge i_clk) begin
        r_p_ab <= i_elem_a * i_elem_b;
        r_p_aa <= i_elem_a * i_elem_a;
        r_p_bb <= i_elem_b * i_elem_b;
    end

    assign n_dot = sat_add(r_dot, r_p_ab);
    assign n_na  = sat_add(r_na, r_p_aa);
    assign n_nb  = sat_add(r_nb, r_p_bb);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
            r_p_last  <= 1'b0;
            r_dot     <= '0;
            r_na      <= '0;
            r_nb      <= '0;
        end else begin
            r_p_valid <= i_valid;
            r_p_last  <= i_last;
            if (r_p_valid) begin
                if (r_p_last) begin
                    r_dot <= '0;
                    r_na  <= '0;
                    r_nb  <= '0;
                end else begin
                    r_dot <= n_dot;
                    r_na  <= n_na;
                    r_nb  <= n_nb;
                end
            end
        end
    end

    assign o_done        = r_p_valid && r_p_last;
    assign o_sums.dot    = n_dot;
    assign o_sums.norm_a = n_na;
    assign o_sums.norm_b = n_nb;

endmodule

// ===== rtl/csu_quot.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity quotient sequencer
// Forms the squared products on a shared multiplier, divides them bit by bit
// and takes an integer square root to get the rounded Q1.15 similarity.
// ----------------------------------------------------------------------------
module csu_quot (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    input  csu_pkg::t_sums               i_sums,
    input  logic [csu_pkg::THR_W-1:0]    i_min_norm_sq,
    output logic                         o_res_valid,
    output csu_pkg::t_result             o_res,
    input  logic                         i_res_ready
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_CHK  = 7'b0000010,
        S_MUL  = 7'b0000100,
        S_CMP  = 7'b0001000,
        S_DIV  = 7'b0010000,
        S_SQRT = 7'b0100000,
        S_OUT  = 7'b1000000
    } t_state;

    localparam int AW = csu_pkg::ACC_W;
    localparam int WW = csu_pkg::WIDE_W;
    localparam int MW = csu_pkg::MUL_W;
    localparam int QW = csu_pkg::QUO_W;
    localparam int RW = csu_pkg::ROOT_W;
    localparam int SW = RW + 2;

    t_state                      r_state;
    t_state                      n_state;
    logic [csu_pkg::CNT_W-1:0]   r_cnt;
    logic [csu_pkg::CNT_W-1:0]   n_cnt;
    logic                        r_pp_vld;
    logic [2:0]                  r_pp_idx;
    logic [AW-1:0]               r_dot;
    logic [AW-1:0]               r_na;
    logic [AW-1:0]               r_nb;
    logic                        r_neg;
    logic [AW-1:0]               r_mag;
    logic                        r_degen;
    logic [WW-1:0]               r_prod;
    logic [WW-1:0]               r_dsq;
    logic [WW-1:0]               r_rem;
    logic [QW-1:0]               r_quo;
    logic [SW-1:0]               r_sq_rem;
    logic [RW-1:0]               r_root;
    logic [csu_pkg::RES_W-1:0]   r_q;

    logic                        degen;
    logic [AW-1:0]               mul_x;
    logic [AW-1:0]               mul_y;
    logic [MW-1:0]               mul_a;
    logic [MW-1:0]               mul_b;
    logic [2*MW-1:0]             mul_p;
    logic [1:0]                  pp_pos;
    logic [WW-1:0]               pp_sh;
    logic [WW-1:0]               rem2;
    logic                        div_ge;
    logic [SW-1:0]               sq_cur;
    logic [SW-1:0]               sq_trial;
    logic                        sq_ge;
    logic [RW-1:0]               root_nx;
    logic [RW:0]                 root_inc;
    logic [csu_pkg::RES_W-1:0]   sim;

    assign degen = (r_na == '0) || (r_nb == '0) ||
                   (r_na < AW'(i_min_norm_sq)) || (r_nb < AW'(i_min_norm_sq));

    assign mul_x = r_cnt[2] ? r_mag : r_na;
    assign mul_y = r_cnt[2] ? r_mag : r_nb;
    assign mul_a = r_cnt[1] ? mul_x[AW-1:MW] : mul_x[MW-1:0];
    assign mul_b = r_cnt[0] ? mul_y[AW-1:MW] : mul_y[MW-1:0];

    csu_mul #(
        .W (MW)
    ) u_mul (
        .i_clk (i_clk),
        .i_a   (mul_a),
        .i_b   (mul_b),
        .o_p   (mul_p)
    );

    assign pp_pos = {1'b0, r_pp_idx[1]} + {1'b0, r_pp_idx[0]};

    always_comb begin
        case (pp_pos)
            2'd0:    pp_sh = WW'(mul_p);
            2'd1:    pp_sh = WW'(mul_p) << MW;
            default: pp_sh = WW'(mul_p) << (2 * MW);
        endcase
    end

    assign rem2   = {r_rem[WW-2:0], 1'b0};
    assign div_ge = rem2 >= r_prod;

    assign sq_cur   = {r_sq_rem[SW-3:0], r_quo[QW-1:QW-2]};
    assign sq_trial = {r_root, 2'b01};
    assign sq_ge    = sq_cur >= sq_trial;
    assign root_nx  = {r_root[RW-2:0], sq_ge};
    assign root_inc = {1'b0, root_nx} + (RW+1)'(1);

    always_comb begin
        n_state = r_state;
        n_cnt   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                n_state = degen ? S_OUT : S_MUL;
            end
            S_MUL: begin
                if (r_cnt == csu_pkg::MUL_LAST) begin
                    n_state = S_CMP;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_CMP: begin
                n_state = (r_dsq >= r_prod) ? S_OUT : S_DIV;
            end
            S_DIV: begin
                if (r_cnt == csu_pkg::DIV_LAST) begin
                    n_state = S_SQRT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_SQRT: begin
                if (r_cnt == csu_pkg::SQRT_LAST) begin
                    n_state = S_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            S_OUT: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_pp_vld <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_pp_vld <= (r_state == S_MUL) && (r_cnt != csu_pkg::MUL_LAST);
        end
    end

    always_ff @(posedge i_clk) begin
        r_pp_idx <= r_cnt[2:0];
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    r_dot <= i_sums.dot;
                    r_na  <= i_sums.norm_a;
                    r_nb  <= i_sums.norm_b;
                end
            end
            S_CHK: begin
                r_neg   <= r_dot[AW-1];
                r_mag   <= r_dot[AW-1] ? ('0 - r_dot) : r_dot;
                r_degen <= degen;
                r_prod  <= '0;
                r_dsq   <= '0;
                r_q     <= '0;
            end
            S_MUL: begin
                if (r_pp_vld) begin
                    if (r_pp_idx[2]) begin
                        r_dsq <= r_dsq + pp_sh;
                    end else begin
                        r_prod <= r_prod + pp_sh;
                    end
                end
            end
            S_CMP: begin
                if (r_dsq >= r_prod) begin
                    r_q <= csu_pkg::Q_ONE;
                end
                r_rem    <= r_dsq;
                r_quo    <= '0;
                r_sq_rem <= '0;
                r_root   <= '0;
            end
            S_DIV: begin
                r_rem <= div_ge ? (rem2 - r_prod) : rem2;
                r_quo <= {r_quo[QW-2:0], div_ge};
            end
            S_SQRT: begin
                r_sq_rem <= sq_ge ? (sq_cur - sq_trial) : sq_cur;
                r_root   <= root_nx;
                r_quo    <= {r_quo[QW-3:0], 2'b00};
                if (r_cnt == csu_pkg::SQRT_LAST) begin
                    r_q <= root_inc[RW:1];
                end
            end
            S_OUT: begin
            end
            default: begin
            end
        endcase
    end

    always_comb begin
        if (r_neg) begin
            sim = '0 - r_q;
        end else if (r_q[csu_pkg::RES_W-1]) begin
            sim = csu_pkg::Q_MAX;
        end else begin
            sim = r_q;
        end
    end

    assign o_res_valid      = (r_state == S_OUT);
    assign o_res.similarity = sim;
    assign o_res.degenerate = r_degen;

`ifndef ASSERT_OFF
    a_start_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |-> (r_state == S_IDLE))
        else $error("Vector end arrived while the quotient sequencer was busy.");

    a_rem_below_divisor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV) |-> (r_rem < r_prod))
        else $error("Division remainder is not below the norm product.");

    a_q_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_OUT) |-> (r_q <= csu_pkg::Q_ONE))
        else $error("Quotient magnitude exceeds one.");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_OUT) && !i_res_ready) |=> (r_state == S_OUT))
        else $error("Pending result was dropped.");
`endif

endmodule

// ===== rtl/cosine_similarity_unit.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity unit
// A non-final element pair is taken every cycle; after the final pair of a
// vector, input is held off until its result has passed the 32-step divider
// and 16-step square root (both skipped if the vector is degenerate or its
// magnitude reaches one) and been taken into the output register.
// Synchronous active-low reset clears the sums, the threshold and all control.
// ----------------------------------------------------------------------------
module cosine_similarity_unit #(
    parameter int ELEM_WIDTH = 16,
    localparam int TDATA_W = ((2 * ELEM_WIDTH + 7) / 8) * 8
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_wr_en,
    input  logic [csu_pkg::THR_W-1:0]    i_cfg_wr_data,
    input  logic                         s_axis_tvalid,
    output logic                         s_axis_tready,
    input  logic [TDATA_W-1:0]           s_axis_tdata,   // elem_a, elem_b
    input  logic                         s_axis_tlast,
    output logic                         m_axis_tvalid,
    input  logic                         m_axis_tready,
    output logic [csu_pkg::RES_W-1:0]    m_axis_tdata,   // similarity
    output logic                         m_axis_tuser    // degenerate
);

    logic [csu_pkg::THR_W-1:0] r_min_norm_sq;
    logic                      r_hold;
    logic                      r_out_valid;
    logic [csu_pkg::RES_W-1:0] r_out_sim;
    logic                      r_out_degen;

    logic                      in_xfer;
    logic                      acc_done;
    csu_pkg::t_sums            sums;
    logic                      res_valid;
    logic                      res_ready;
    csu_pkg::t_result          res;

    assign s_axis_tready = !r_hold;
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign res_ready     = !r_out_valid || m_axis_tready;

    csu_accum #(
        .ELEM_WIDTH (ELEM_WIDTH)
    ) u_accum (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (in_xfer),
        .i_elem_a (s_axis_tdata[ELEM_WIDTH-1:0]),
        .i_elem_b (s_axis_tdata[2*ELEM_WIDTH-1:ELEM_WIDTH]),
        .i_last   (s_axis_tlast),
        .o_done   (acc_done),
        .o_sums   (sums)
    );

    csu_quot u_quot (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (acc_done),
        .i_sums        (sums),
        .i_min_norm_sq (r_min_norm_sq),
        .o_res_valid   (res_valid),
        .o_res         (res),
        .i_res_ready   (res_ready)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_norm_sq <= '0;
            r_hold        <= 1'b0;
            r_out_valid   <= 1'b0;
        end else begin
            if (i_cfg_wr_en) begin
                r_min_norm_sq <= i_cfg_wr_data;
            end
            if (in_xfer && s_axis_tlast) begin
                r_hold <= 1'b1;
            end else if (res_valid && res_ready) begin
                r_hold <= 1'b0;
            end
            if (res_valid && res_ready) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_valid && res_ready) begin
            r_out_sim   <= res.similarity;
            r_out_degen <= res.degenerate;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_sim;
    assign m_axis_tuser  = r_out_degen;

endmodule

// ===== tb/sv/csu_checker.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity checker
// Watches the configuration port and both stream channels of the cosine
// similarity unit, predicts the similarity of every vector from its own copy
// of the running sums and threshold, and compares each result transfer.
// ----------------------------------------------------------------------------
module cosine_similarity_checker (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_wr_en,
    input  logic [csu_pkg::THR_W-1:0] i_cfg_wr_data,
    input  logic                      i_s_tvalid,
    input  logic                      i_s_tready,
    input  logic [31:0]               i_s_tdata,   // elem_a, elem_b
    input  logic                      i_s_tlast,
    input  logic                      i_m_tvalid,
    input  logic                      i_m_tready,
    input  logic [csu_pkg::RES_W-1:0] i_m_tdata,   // similarity
    input  logic                      i_m_tuser,   // degenerate
    output int                        o_fail_count,
    output int                        o_pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import csu_pkg::*;

    localparam longint SUM_MAX = (longint'(1) <<< (ACC_W - 1)) - 1;
    localparam longint SUM_MIN = -SUM_MAX - 1;
    localparam int     UNITY   = 1 << (RES_W - 1);

    longint  dot_acc;
    longint  energy_a;
    longint  energy_b;
    longint  threshold;
    int      failures;
    t_result similarity_queue[$];

    function automatic longint sat_sum(input longint acc, input longint add);
        longint s;
        s = acc + add;
        if (s > SUM_MAX) return SUM_MAX;
        if (s < SUM_MIN) return SUM_MIN;
        return s;
    endfunction

    // Largest q in [0, 1.0] with (2q - 1)^2 * na * nb <= dot^2 * 2^32.
    function automatic int cos_magnitude(input logic [ACC_W-1:0] mag, na, nb);
        logic [127:0] prod;
        logic [127:0] rhs;
        logic [127:0] t;
        int           lo;
        int           hi;
        int           mid;
        prod = 128'(na) * 128'(nb);
        rhs  = (128'(mag) * 128'(mag)) << 32;
        lo   = 0;
        hi   = UNITY;
        while (lo < hi) begin
            mid = (lo + hi + 1) / 2;
            t   = 128'(2 * mid - 1);
            if (prod * t * t <= rhs) begin
                lo = mid;
            end else begin
                hi = mid - 1;
            end
        end
        return lo;
    endfunction

    task automatic accumulate_pair(input logic signed [15:0] a, b, input logic lst);
        t_result res;
        longint  mag;
        int      q;
        int      sim;
        dot_acc  = sat_sum(dot_acc, longint'(a) * longint'(b));
        energy_a = sat_sum(energy_a, longint'(a) * longint'(a));
        energy_b = sat_sum(energy_b, longint'(b) * longint'(b));
        if (lst) begin
            if (energy_a == 0 || energy_b == 0 || energy_a < threshold ||
                energy_b < threshold) begin
                res.similarity = '0;
                res.degenerate = 1'b1;
            end else begin
                mag = (dot_acc < 0) ? -dot_acc : dot_acc;
                q   = cos_magnitude(ACC_W'(mag), ACC_W'(energy_a), ACC_W'(energy_b));
                if (dot_acc < 0) begin
                    sim = -q;
                end else begin
                    sim = (q >= UNITY) ? UNITY - 1 : q;
                end
                res.similarity = RES_W'(sim);
                res.degenerate = 1'b0;
            end
            similarity_queue.push_back(res);
            dot_acc  = 0;
            energy_a = 0;
            energy_b = 0;
        end
    endtask

    always @(posedge i_clk) begin : monitor
        t_result want;
        if (!i_rst_n) begin
            dot_acc   = 0;
            energy_a  = 0;
            energy_b  = 0;
            threshold = 0;
            failures  = 0;
            similarity_queue.delete();
        end else begin
            if (i_cfg_wr_en) begin
                threshold = longint'(i_cfg_wr_data);
            end
            if (i_s_tvalid && i_s_tready) begin
                accumulate_pair(i_s_tdata[15:0], i_s_tdata[31:16], i_s_tlast);
            end
            if (i_m_tvalid && i_m_tready) begin
                if (similarity_queue.size() == 0) begin
                    failures++;
                    $display("%0t: unexpected result transfer, expected none, actual %0d/%0b",
                             $time, $signed(i_m_tdata), i_m_tuser);
                end else begin
                    want = similarity_queue.pop_front();
                    if (want.similarity !== i_m_tdata) begin
                        failures++;
                        $display("%0t: similarity expected %0d actual %0d", $time,
                                 $signed(want.similarity), $signed(i_m_tdata));
                    end
                    if (want.degenerate !== i_m_tuser) begin
                        failures++;
                        $display("%0t: degenerate expected %0b actual %0b", $time,
                                 want.degenerate, i_m_tuser);
                    end
                end
            end
        end
        o_fail_count <= failures;
        o_pending    <= similarity_queue.size();
    end

endmodule

// ===== tb/sv/tb_top.sv =====
// ----------------------------------------------------------------------------
// Cosine similarity unit testbench
// Drives directed and random element-pair vectors with random idling on both
// channels, reprograms the norm threshold between phases, and reports the
// verdict from the failure and pending counts of the checker.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import csu_pkg::*;

    localparam int IDLE_PCT       = 34;
    localparam int RANDOM_PAIRS   = 1350;
    localparam int WATCHDOG_LIMIT = 5000;
    localparam int SETTLE_CYCLES  = 70;
    localparam logic [THR_W-1:0] THR_MAX = '1;

    typedef enum int {
        VEC_FULL,
        VEC_SMALL,
        VEC_UNIT,
        VEC_TINY,
        VEC_ZERO_A,
        VEC_ZERO_B,
        VEC_PARALLEL,
        VEC_OPPOSED
    } vec_kind_e;

    logic             i_clk = 1'b0;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [THR_W-1:0] i_cfg_wr_data;
    logic             s_axis_tvalid;
    logic             s_axis_tready;
    logic [31:0]      s_axis_tdata;   // elem_a, elem_b
    logic             s_axis_tlast;
    logic             m_axis_tvalid;
    logic             m_axis_tready;
    logic [RES_W-1:0] m_axis_tdata;   // similarity
    logic             m_axis_tuser;   // degenerate

    int fail_count;
    int pending;
    bit calm;
    int pairs_sent;

    cosine_similarity_unit #(.ELEM_WIDTH(16)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    cosine_similarity_checker u_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_s_tvalid    (s_axis_tvalid),
        .i_s_tready    (s_axis_tready),
        .i_s_tdata     (s_axis_tdata),
        .i_s_tlast     (s_axis_tlast),
        .i_m_tvalid    (m_axis_tvalid),
        .i_m_tready    (m_axis_tready),
        .i_m_tdata     (m_axis_tdata),
        .i_m_tuser     (m_axis_tuser),
        .o_fail_count  (fail_count),
        .o_pending     (pending)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(negedge i_clk) begin
        m_axis_tready <= calm || ($urandom_range(0, 99) >= IDLE_PCT);
    end

    task automatic send_pair(input logic signed [15:0] a, b, input logic lst);
        while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            s_axis_tlast  <= 1'($urandom);
            @(negedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {b, a};
        s_axis_tlast  <= lst;
        do @(posedge i_clk); while (!s_axis_tready);
        @(negedge i_clk);
        pairs_sent++;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_threshold(input logic [THR_W-1:0] value);
        settle();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= value;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
    endtask

    function automatic logic signed [15:0] pick_elem(input vec_kind_e kind);
        case (kind)
            VEC_SMALL: return 16'(int'($urandom_range(0, 128)) - 64);
            VEC_UNIT:  return 16'(int'($urandom_range(0, 8192)) - 4096);
            VEC_TINY:  return 16'(int'($urandom_range(0, 8)) - 4);
            default:   return 16'($urandom);
        endcase
    endfunction

    task automatic send_vector(input int len, input vec_kind_e kind);
        logic signed [15:0] a;
        logic signed [15:0] b;
        for (int i = 0; i < len; i++) begin
            a = pick_elem(kind);
            b = pick_elem(kind);
            case (kind)
                VEC_ZERO_A:   a = '0;
                VEC_ZERO_B:   b = '0;
                VEC_PARALLEL: b = a;
                VEC_OPPOSED: begin
                    a = 16'(int'($urandom_range(0, 65534)) - 32767);
                    b = -a;
                end
                default: ;
            endcase
            send_pair(a, b, i == len - 1);
        end
    endtask

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        wait (i_rst_n === 1'b1);
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("Mismatches found");
        $finish;
    end

    initial begin : stimulus
        int        phase_end;
        int        len;
        vec_kind_e kind;
        i_rst_n       = 1'b0;
        i_cfg_wr_en   = 1'b0;
        i_cfg_wr_data = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        calm          = 1'b0;
        pairs_sent    = 0;
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        write_threshold('0);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(16'sd1, -16'sd1, 1'b1);
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd4096, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd4096, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b0);
        send_pair(-16'sd32768, 16'sd32767, 1'b0);
        send_pair(16'sd1, 16'sd1, 1'b1);

        write_threshold(THR_MAX);
        send_pair(16'sd4096, 16'sd4096, 1'b1);
        send_pair(16'sd4095, 16'sd4096, 1'b1);
        send_pair(16'sd4096, 16'sd4095, 1'b1);
        send_pair(16'sd4096, -16'sd4096, 1'b1);

        pairs_sent = 0;
        while (pairs_sent < RANDOM_PAIRS) begin
            case ($urandom_range(0, 3))
                0:       write_threshold('0);
                1:       write_threshold(THR_MAX);
                2:       write_threshold(THR_W'($urandom));
                default: write_threshold(THR_W'($urandom_range(0, 1 << 16)));
            endcase
            phase_end = pairs_sent + int'($urandom_range(120, 260));
            while (pairs_sent < phase_end && pairs_sent < RANDOM_PAIRS) begin
                calm = (pairs_sent >= 500 && pairs_sent < 750);
                len  = ($urandom_range(0, 49) == 0) ? int'($urandom_range(505, 530))
                                                    : int'($urandom_range(1, 20));
                kind = vec_kind_e'($urandom_range(0, 7));
                send_vector(len, kind);
                if ($urandom_range(0, 9) == 0) begin
                    settle();
                end
            end
        end
        calm = 1'b0;

        settle();
        if (fail_count == 0 && pending == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
